// ===== rtl/etd_pkg.sv =====
// ----------------------------------------------------------------------------
// etd_pkg
// shared types and character constants for the escaped text decoder
// ----------------------------------------------------------------------------
package etd_pkg;

  typedef struct packed {
    logic [7:0] coded_byte;
    logic       string_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0] plain_byte;
    logic       run_last;
  } out_item_t;

  // repeat count of one command, 1 to 9
  localparam int unsigned CntW = 4;

  typedef struct packed {
    logic [7:0]      val;
    logic [CntW-1:0] cnt;
  } cmd_t;

  localparam logic [7:0] ChDigitOne  = 8'h31;  // '1'
  localparam logic [7:0] ChDigitNine = 8'h39;  // '9'
  localparam logic [7:0] ChDigitZero = 8'h30;  // '0'
  localparam logic [7:0] ChCtrlLow   = 8'h41;  // 'A'
  localparam logic [7:0] ChCtrlHigh  = 8'h5F;  // 'A' + 30
  localparam logic [7:0] ChUnder     = 8'h5F;  // '_'
  localparam logic [7:0] ChTilde     = 8'h7E;  // '~'
  localparam logic [7:0] ChCaret     = 8'h5E;  // '^'
  localparam logic [7:0] ChColon     = 8'h3A;  // ':'
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChLowerN    = 8'h6E;
  localparam logic [7:0] ChLowerR    = 8'h72;
  localparam logic [7:0] ChEquals    = 8'h3D;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChNewline   = 8'h0A;
  localparam logic [7:0] ChCr        = 8'h0D;
  localparam logic [7:0] ChNull      = 8'h00;

endpackage

// ===== rtl/etd_front.sv =====
// ----------------------------------------------------------------------------
// etd_front
// classifies each coded byte and turns it into a value and repeat count
// ----------------------------------------------------------------------------
module etd_front import etd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_item_t item_i,
  output logic     cmd_push_o,
  output cmd_t     cmd_o
);

  logic       esc_q, esc_d;
  logic       ctl_q, ctl_d;
  logic       ntm_q, ntm_d;
  logic [7:0] prev_q, prev_d;
  logic       prev_vld_q, prev_vld_d;

  logic       esc_c, ctl_c, ntm_c, prev_vld_c;
  logic [7:0] prev_c, c;
  logic       emit;
  logic [7:0] val;
  logic [CntW-1:0] cnt;

  always_comb begin
    c          = item_i.coded_byte;
    // start of string clears state before decoding
    esc_c      = item_i.string_start ? 1'b0 : esc_q;
    ctl_c      = item_i.string_start ? 1'b0 : ctl_q;
    ntm_c      = item_i.string_start ? 1'b0 : ntm_q;
    prev_c     = item_i.string_start ? 8'h00 : prev_q;
    prev_vld_c = item_i.string_start ? 1'b0 : prev_vld_q;

    emit  = 1'b0;
    val   = ChNull;
    cnt   = CntW'(1);
    esc_d = 1'b0;
    ctl_d = 1'b0;
    ntm_d = ntm_c;

    if (esc_c) begin
      if (c == ChLowerN) begin
        val = ChNewline; emit = 1'b1;
      end else if (c == ChLowerR) begin
        val = ChCr; emit = 1'b1;
      end else if (c == ChDigitZero) begin
        val = ChNull; emit = 1'b1;
      end else if (c == ChColon) begin
        val = ChEquals; emit = 1'b1;
      end else if (c inside {[ChDigitOne:ChDigitNine]}) begin
        val  = prev_c;
        cnt  = c[CntW-1:0];
        emit = prev_vld_c;
      end else begin
        val = c; emit = 1'b1;
      end
    end else if (ctl_c) begin
      if (c == ChTilde) begin
        val = ChNull; emit = 1'b1; ntm_d = 1'b1;
      end else if (c inside {[ChCtrlLow:ChCtrlHigh]}) begin
        val = {3'b000, c[4:0]}; emit = 1'b1;
      end
    end else begin
      if (c == ChUnder) begin
        val = ChSpace; emit = 1'b1;
      end else if (c == ChTilde) begin
        val = ntm_c ? ChNull : ChTilde; emit = 1'b1;
      end else if (c == ChBackslash) begin
        esc_d = 1'b1;
      end else if (c == ChCaret) begin
        ctl_d = 1'b1;
      end else begin
        val = c; emit = 1'b1;
      end
    end

    prev_d     = emit ? val : prev_c;
    prev_vld_d = prev_vld_c | emit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q      <= 1'b0;
      ctl_q      <= 1'b0;
      ntm_q      <= 1'b0;
      prev_q     <= 8'h00;
      prev_vld_q <= 1'b0;
    end else if (accept_i) begin
      esc_q      <= esc_d;
      ctl_q      <= ctl_d;
      ntm_q      <= ntm_d;
      prev_q     <= prev_d;
      prev_vld_q <= prev_vld_d;
    end
  end

  assign cmd_push_o = accept_i & emit;
  assign cmd_o      = '{val: val, cnt: cnt};

endmodule

// ===== rtl/etd_fifo.sv =====
// ----------------------------------------------------------------------------
// etd_fifo
// short command queue between the classifier and the expander
// ----------------------------------------------------------------------------
module etd_fifo import etd_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t data_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  cmd_t          mem_q [Depth];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [AW:0]   cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    cnt_d = cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign full_o  = (cnt_q == (AW+1)'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (AW+1)'(Depth))
    else $error("command queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("push into full command queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_o |-> !pop_i)
    else $error("pop from empty command queue");

endmodule

// ===== rtl/etd_back.sv =====
// ----------------------------------------------------------------------------
// etd_back
// expands each command into its run of output bytes, one per transfer
// ----------------------------------------------------------------------------
module etd_back import etd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      cmd_pop_o,
  input  logic      pop_i,
  output logic      empty_o,
  output out_item_t out_item_o
);

  logic            busy_q, busy_d;
  logic [7:0]      val_q, val_d;
  logic [CntW-1:0] rem_q, rem_d;
  logic            last, taken, load;

  assign last  = (rem_q == CntW'(1));
  assign taken = pop_i & busy_q;
  assign load  = cmd_valid_i & (~busy_q | (taken & last));

  always_comb begin
    busy_d = busy_q;
    val_d  = val_q;
    rem_d  = rem_q;
    if (load) begin
      busy_d = 1'b1;
      val_d  = cmd_i.val;
      rem_d  = cmd_i.cnt;
    end else if (taken) begin
      if (last) begin
        busy_d = 1'b0;
      end else begin
        rem_d = rem_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rem_q  <= '0;
    end else begin
      busy_q <= busy_d;
      rem_q  <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign cmd_pop_o  = load;
  assign empty_o    = ~busy_q;
  assign out_item_o = '{plain_byte: val_q, run_last: last};

  a_rem_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (rem_q != '0 && rem_q <= CntW'(9)))
    else $error("run count out of range while busy");

  a_hold_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !pop_i) |=> (busy_q && $stable(rem_q) && $stable(val_q)))
    else $error("waiting output changed without transfer");

  a_count_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && pop_i && !last) |=> (busy_q && rem_q == $past(rem_q) - CntW'(1)))
    else $error("run count did not step down");

endmodule

// ===== rtl/escaped_text_decoder.sv =====
// ----------------------------------------------------------------------------
// escaped_text_decoder
// decodes escaped text one coded byte at a time into plain bytes
// ----------------------------------------------------------------------------
// path: with the expander idle, a byte that decodes is written into the command
//   queue and then loaded into the output register, where it shows on the output
// throughput: one coded byte a cycle while the queue has room; a repeat holds the
//   expander for up to nine output bytes, one per pop, as the queue absorbs input
// input stalls (full high) only when the CmdDepth-entry command queue is full
// reset: all decoder flags and the last-byte record clear, queue and output empty
// ----------------------------------------------------------------------------
module escaped_text_decoder import etd_pkg::*; #(
  parameter int unsigned CmdDepth = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  // input side, queue style
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item_i,
  // result side, queue style
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item_o
);

  logic accept;
  logic cmd_push, cmd_full, cmd_valid, cmd_pop;
  cmd_t cmd_in, cmd_out;

  // a coded byte transfers whenever the command queue has room
  assign full   = cmd_full;
  assign accept = push & ~cmd_full;

  // front: tracks escape, caret and null-tilde state plus the last emitted byte
  etd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (in_item_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  // decoupling queue of value/count commands
  etd_fifo #(
    .Depth (CmdDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .data_o  (cmd_out)
  );

  // back: registered output, replays the value for the run length
  etd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the escaped text decoder: a scoreboard decodes
// every accepted coded byte on its own and holds the plain bytes that must
// follow, and each result transfer is checked against the oldest of them
// ----------------------------------------------------------------------------
module tb import etd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // scoreboard: own copy of the decoder state plus the plain bytes still due
  class plain_text_board;
    logic        esc_waiting;
    logic        ctrl_waiting;
    logic        tilde_is_null;
    logic [7:0]  last_plain;
    logic        last_seen;
    out_item_t   plain_due[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
      clear_string();
    endfunction

    function void clear_string();
      esc_waiting   = 1'b0;
      ctrl_waiting  = 1'b0;
      tilde_is_null = 1'b0;
      last_plain    = ChNull;
      last_seen     = 1'b0;
    endfunction

    function int unsigned pending();
      return plain_due.size();
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("%0t ns: mismatch: %s", $time, what);
    endtask

    // decode one accepted coded byte and queue the plain bytes it yields
    function void note_coded(in_item_t it);
      logic [7:0]  c;
      logic [7:0]  val;
      logic        emit;
      int unsigned count;
      out_item_t   e;
      c     = it.coded_byte;
      val   = ChNull;
      emit  = 1'b0;
      count = 1;
      if (it.string_start) clear_string();
      if (esc_waiting) begin
        esc_waiting = 1'b0;
        if (c == ChLowerN) begin
          val  = ChNewline;
          emit = 1'b1;
        end else if (c == ChLowerR) begin
          val  = ChCr;
          emit = 1'b1;
        end else if (c == ChDigitZero) begin
          val  = ChNull;
          emit = 1'b1;
        end else if (c == ChColon) begin
          val  = ChEquals;
          emit = 1'b1;
        end else if (c >= ChDigitOne && c <= ChDigitNine) begin
          if (last_seen) begin
            val   = last_plain;
            count = c - ChDigitZero;
            emit  = 1'b1;
          end
        end else begin
          val  = c;
          emit = 1'b1;
        end
      end else if (ctrl_waiting) begin
        ctrl_waiting = 1'b0;
        if (c == ChTilde) begin
          val           = ChNull;
          emit          = 1'b1;
          tilde_is_null = 1'b1;
        end else if (c >= ChCtrlLow && c <= ChCtrlHigh) begin
          val  = c - ChCtrlLow + 8'd1;
          emit = 1'b1;
        end
      end else begin
        if (c == ChUnder) begin
          val  = ChSpace;
          emit = 1'b1;
        end else if (c == ChTilde) begin
          val  = tilde_is_null ? ChNull : ChTilde;
          emit = 1'b1;
        end else if (c == ChBackslash) begin
          esc_waiting = 1'b1;
        end else if (c == ChCaret) begin
          ctrl_waiting = 1'b1;
        end else begin
          val  = c;
          emit = 1'b1;
        end
      end
      if (emit) begin
        for (int unsigned k = 0; k < count; k++) begin
          e.plain_byte = val;
          e.run_last   = (k + 1 == count);
          plain_due.push_back(e);
        end
        last_plain = val;
        last_seen  = 1'b1;
      end
    endfunction

    // compare one result transfer with the oldest plain byte due
    task check_plain(out_item_t got);
      out_item_t want;
      if (plain_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result byte %02h last %0b",
                                  got.plain_byte, got.run_last));
      end else begin
        want = plain_due.pop_front();
        if (got.plain_byte !== want.plain_byte)
          report_mismatch($sformatf("plain_byte %02h, wanted %02h",
                                    got.plain_byte, want.plain_byte));
        if (got.run_last !== want.run_last)
          report_mismatch($sformatf("run_last %0b, wanted %0b on byte %02h",
                                    got.run_last, want.run_last, want.plain_byte));
      end
    endtask
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      push;
  logic      full;
  in_item_t  in_item_i;
  logic      empty;
  logic      pop;
  out_item_t out_item_o;

  // while set, neither side idles
  logic      no_gaps;

  plain_text_board board;

  escaped_text_decoder u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

  // 8 ns clock
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // result side: pop with a probability of about 65 in a hundred, held high throughout the gap-free stretch
  always @(negedge clk_i) begin
    pop <= no_gaps || ($urandom_range(99) >= 35);
  end

  // every result transfer goes to the scoreboard
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) board.check_plain(out_item_o);
  end

  // one input transfer, entered and left at a falling edge; random idle cycles first
  task automatic send_coded(input logic [7:0] c, input logic start);
    while (!no_gaps && $urandom_range(99) < 35) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push                   <= 1'b1;
    in_item_i.coded_byte   <= c;
    in_item_i.string_start <= start;
    do @(posedge clk_i); while (full);
    board.note_coded('{coded_byte: c, string_start: start});
    @(negedge clk_i);
  endtask

  // second byte of an escape pair, mostly the special codes
  function automatic logic [7:0] escaped_pick();
    case ($urandom_range(5))
      0:       return ChLowerN;
      1:       return ChLowerR;
      2:       return ChDigitZero;
      3:       return ChColon;
      4:       return 8'($urandom_range(ChDigitOne, ChDigitNine));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // second byte of a caret pair
  function automatic logic [7:0] control_pick();
    case ($urandom_range(3))
      0, 1:    return 8'($urandom_range(ChCtrlLow, ChCtrlHigh));
      2:       return ChTilde;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  initial begin
    int unsigned sent;
    int unsigned pick;
    logic [7:0]  c;
    logic        start;

    rst_ni    = 1'b0;
    push      = 1'b0;
    pop       = 1'b0;
    in_item_i = '0;
    no_gaps   = 1'b0;
    board     = new();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: field extremes and each decoding rule
    send_coded(ChUnder, 1'b1);        // underscore to space
    send_coded(ChTilde, 1'b0);        // bare tilde before null-tilde mode
    send_coded(8'h00, 1'b0);
    send_coded(8'hFF, 1'b0);
    send_coded(ChBackslash, 1'b1);    // new string clears the last byte
    send_coded(ChDigitNine, 1'b0);    // repeat with nothing to repeat
    send_coded(ChBackslash, 1'b0);
    send_coded(ChLowerN, 1'b0);
    send_coded(ChBackslash, 1'b0);
    send_coded(ChDigitNine, 1'b0);    // nine newlines, longest run
    send_coded(ChBackslash, 1'b0);
    send_coded(ChDigitZero, 1'b0);
    send_coded(ChBackslash, 1'b0);
    send_coded(ChColon, 1'b0);
    send_coded(ChCaret, 1'b0);
    send_coded(ChCtrlLow, 1'b0);
    send_coded(ChCaret, 1'b0);
    send_coded(ChCtrlHigh, 1'b0);
    send_coded(ChCaret, 1'b0);
    send_coded(8'h60, 1'b0);          // caret with an unlisted byte: nothing
    send_coded(ChCaret, 1'b0);
    send_coded(ChTilde, 1'b0);        // caret-tilde switches the mode on
    send_coded(ChTilde, 1'b0);        // bare tilde now decodes to null
    send_coded(ChBackslash, 1'b0);
    send_coded(ChTilde, 1'b0);        // escaped tilde stays literal

    // random: mostly well-formed tokens with random content, some noise
    sent = 0;
    while (sent < 460) begin
      no_gaps = (sent >= 150 && sent < 260);
      pick    = $urandom_range(99);
      start   = ($urandom_range(99) < 6);
      if (pick < 8) begin
        send_coded(8'($urandom_range(255)), start);
        sent++;
      end else if (pick < 35) begin
        c = 8'($urandom_range(255));
        if (c == ChBackslash || c == ChCaret) c = ChTilde;
        send_coded(c, start);
        sent++;
      end else if (pick < 45) begin
        send_coded(ChUnder, start);
        sent++;
      end else if (pick < 55) begin
        send_coded(ChTilde, start);
        sent++;
      end else if (pick < 78) begin
        send_coded(ChBackslash, start);
        send_coded(escaped_pick(), $urandom_range(99) < 3);  // rare broken pair
        sent += 2;
      end else begin
        send_coded(ChCaret, start);
        send_coded(control_pick(), $urandom_range(99) < 3);
        sent += 2;
      end
    end
    push    <= 1'b0;
    no_gaps  = 1'b0;

    // drain, then keep the clock running so that stray results would show
    while (board.pending() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);

    if (board.mismatches == 0) begin
      $display("escaped_text_decoder regression: pass");
    end else begin
      $display("escaped_text_decoder regression: fail");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2ms;
    $display("escaped_text_decoder regression: fail");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/etd_pkg.sv
rtl/etd_front.sv
rtl/etd_fifo.sv
rtl/etd_back.sv
rtl/escaped_text_decoder.sv
test/tb.sv
